### rtl/core/bsws_pkg.sv
// shared types and constants for the bounded stack with search
`timescale 1ns / 1ps
`default_nettype none

package bsws_pkg;

    // payload widths fixed by the interface
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W = 7;
    localparam int unsigned FILL_W = 8;

    // default number of stack entries
    localparam int unsigned DEFAULT_STACK_DEPTH = 128;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } op_kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

### rtl/core/bsws_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bsws_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/bounded_stack_with_search.sv
// Bounded LIFO stack of 32-bit words with top-down key search, one item in flight.
// A push goes straight to the emit state; a pop or peek passes through the read state
// for the registered ram data; a search walks the scan state over at most STACK_DEPTH
// entries. Input is taken only while idle, so the next input beat waits until the
// previous result sits in the output register; search is bound by the single ram read
// port (one entry a cycle). Reset clears count and output valid.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_search #(
    parameter int unsigned STACK_DEPTH = bsws_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [bsws_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [bsws_pkg::WORD_W-1:0]   operand,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic             [bsws_pkg::STATUS_W-1:0] status,
    output logic signed      [bsws_pkg::WORD_W-1:0]   word,
    output logic             [bsws_pkg::POS_W-1:0]    position,
    output logic             [bsws_pkg::FILL_W-1:0]   fill_count
);

    import bsws_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;

    // working payload
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    status_t             res_status_reg, res_status_next;
    logic [WORD_W-1:0]   res_word_reg, res_word_next;
    logic [ADDR_W-1:0]   res_pos_reg, res_pos_next;

    // output register
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [FILL_W-1:0]   fill_count_reg, fill_count_next;

    // ram access
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic [CNT_W-1:0]    count_m1;
    logic [ADDR_W-1:0]   top_addr;
    logic                is_full;
    logic                is_empty;

    // stack store
    bsws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stack pointer helpers
    assign count_m1 = count_reg - CNT_W'(1);
    assign top_addr = count_m1[ADDR_W-1:0];
    assign is_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign is_empty = (count_reg == CNT_W'(0));

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        res_pos_reg    <= res_pos_next;
        status_reg     <= status_next;
        word_reg       <= word_next;
        position_reg   <= position_next;
        fill_count_reg <= fill_count_next;
    end

    // sequencer: accesses are serialised, so a write always lands before a later read
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        res_pos_next    = res_pos_reg;
        status_next     = status_reg;
        word_next       = word_reg;
        position_next   = position_reg;
        fill_count_next = fill_count_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = operand;
        rd_addr         = top_addr;

        // output beat taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = operand;
                    case (op_kind_t'(kind))
                        OP_PUSH:
                        begin
                            state_next = S_EMIT;
                            if (is_full)
                            begin
                                res_status_next = ST_OVERFLOW;
                                res_word_next   = '0;
                                res_pos_next    = '0;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                res_word_next   = operand;
                                res_pos_next    = count_reg[ADDR_W-1:0];
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (is_empty)
                            begin
                                state_next      = S_EMIT;
                                res_status_next = ST_EMPTY;
                                res_word_next   = '0;
                                res_pos_next    = '0;
                            end
                            else
                            begin
                                state_next = S_READ;
                                idx_next   = top_addr;
                                if (op_kind_t'(kind) == OP_POP)
                                begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                state_next      = S_EMIT;
                                res_status_next = ST_NOT_FOUND;
                                res_word_next   = '0;
                                res_pos_next    = '0;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                idx_next   = top_addr;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // top word arrives from the ram
            S_READ:
            begin
                state_next      = S_EMIT;
                res_status_next = ST_OK;
                res_word_next   = rd_data;
                res_pos_next    = idx_reg;
            end

            // compare one entry a cycle, walking down
            S_SCAN:
            begin
                rd_addr = idx_reg - ADDR_W'(1);
                if (rd_data == key_reg)
                begin
                    state_next      = S_EMIT;
                    res_status_next = ST_OK;
                    res_word_next   = rd_data;
                    res_pos_next    = idx_reg;
                end
                else if (idx_reg == ADDR_W'(0))
                begin
                    state_next      = S_EMIT;
                    res_status_next = ST_NOT_FOUND;
                    res_word_next   = '0;
                    res_pos_next    = '0;
                end
                else
                begin
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end

            // hand the result over once the output register is free
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    word_next       = res_word_reg;
                    position_next   = POS_W'(res_pos_reg);
                    fill_count_next = FILL_W'(count_reg);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ports
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign word       = word_reg;
    assign position   = position_reg;
    assign fill_count = fill_count_reg;

    // entry count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    // an accepted push with room grows the stack by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == OP_PUSH && !is_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance entry count");

    // a search only walks a non-empty stack
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !is_empty)
        else $error("search scanning an empty stack");

    // empty status goes with a zero fill count
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> fill_count == FILL_W'(0))
        else $error("empty status with entries stored");

    // overflow status goes with a full stack
    a_overflow_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> fill_count == FILL_W'(STACK_DEPTH))
        else $error("overflow status without a full stack");

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the bounded stack with search, driven from directed and random beats
`timescale 1ns / 1ps

module tb_top;

    import bsws_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_TARGET = 550;
    localparam int STEADY_FIRST = 100;
    localparam int STEADY_LAST = 200;
    localparam int HOLD_START = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    // one result beat as the block reports it
    typedef struct packed {
        status_t                  st;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic [FILL_W-1:0]        fill;
    } stack_result_t;

    // one directed beat, with the result typed in where it is obvious
    typedef struct packed {
        op_kind_t                 op;
        logic signed [WORD_W-1:0] arg;
        logic                     typed;
        stack_result_t            res;
    } dir_row_t;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } phase_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] operand;
    logic                     out_valid;
    logic                     out_ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         position;
    logic [FILL_W-1:0]        fill_count;

    // shadow copy of the stack contents
    logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
    int                       model_fill;

    stack_result_t pending_results [$];
    dir_row_t      directed_rows [NUM_DIRECTED];
    int            fail_count;
    int            idle_cycles;
    bit            steady_run;

    bounded_stack_with_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .operand    (operand),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .word       (word),
        .position   (position),
        .fill_count (fill_count)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted result of one operation, updating the shadow stack
    function automatic stack_result_t predict_stack_op(input op_kind_t op,
                                                       input logic signed [WORD_W-1:0] arg);
        stack_result_t res;
        int            idx;
        res = '0;
        res.st = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (model_fill >= STACK_DEPTH)
                begin
                    res.st = ST_OVERFLOW;
                end
                else
                begin
                    model_words[model_fill] = arg;
                    res.value = arg;
                    res.pos = model_fill[POS_W-1:0];
                    model_fill++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (model_fill == 0)
                begin
                    res.st = ST_EMPTY;
                end
                else
                begin
                    idx = model_fill - 1;
                    res.value = model_words[idx];
                    res.pos = idx[POS_W-1:0];
                    if (op == OP_POP)
                        model_fill = idx;
                end
            end
            default:
            begin
                // top-down scan, first match wins
                res.st = ST_NOT_FOUND;
                for (idx = model_fill - 1; idx >= 0; idx--)
                begin
                    if (model_words[idx] == arg)
                    begin
                        res.st = ST_OK;
                        res.value = model_words[idx];
                        res.pos = idx[POS_W-1:0];
                        break;
                    end
                end
            end
        endcase
        res.fill = model_fill[FILL_W-1:0];
        return res;
    endfunction

    function automatic dir_row_t dir_row(input op_kind_t op, input logic signed [WORD_W-1:0] arg,
                                         input logic typed, input status_t st,
                                         input logic signed [WORD_W-1:0] value,
                                         input int pos, input int fill);
        dir_row_t row;
        row.op = op;
        row.arg = arg;
        row.typed = typed;
        row.res.st = st;
        row.res.value = value;
        row.res.pos = pos[POS_W-1:0];
        row.res.fill = fill[FILL_W-1:0];
        return row;
    endfunction

    // values with extremes and a small pool so that duplicates occur
    function automatic logic signed [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        else if (r < 35)
            return $urandom_range(15);
        else
            return $urandom;
    endfunction

    // search keys mostly taken from the stored words
    function automatic logic signed [WORD_W-1:0] pick_key();
        if (model_fill > 0 && $urandom_range(99) < 60)
            return model_words[$urandom_range(model_fill - 1)];
        return pick_value();
    endfunction

    function automatic op_kind_t choose_op(input phase_t ph);
        int r;
        r = $urandom_range(99);
        case (ph)
            PHASE_FILL:
            begin
                if (r < 80) return OP_PUSH;
                if (r < 85) return OP_POP;
                if (r < 90) return OP_PEEK;
                return OP_SEARCH;
            end
            PHASE_DRAIN:
            begin
                if (r < 75) return OP_POP;
                if (r < 80) return OP_PUSH;
                if (r < 90) return OP_PEEK;
                return OP_SEARCH;
            end
            default:
            begin
                if (r < 35) return OP_PUSH;
                if (r < 60) return OP_POP;
                if (r < 75) return OP_PEEK;
                return OP_SEARCH;
            end
        endcase
    endfunction

    // offer one input beat and log its expected result on acceptance
    task automatic offer(input op_kind_t op, input logic signed [WORD_W-1:0] arg,
                         input logic typed, input stack_result_t typed_res);
        stack_result_t pred;
        if (!steady_run && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        operand <= arg;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_stack_op(op, arg);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic report_field(input string name, input logic [WORD_W-1:0] exp_val,
                                input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // stimulus
    initial
    begin
        int            i;
        int            random_items;
        int            refusals;
        int            phase_items;
        phase_t        ph;
        op_kind_t      op;
        logic signed [WORD_W-1:0] arg;
        stack_result_t no_res;

        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        operand = '0;
        model_fill = 0;
        fail_count = 0;
        steady_run = 1'b0;
        no_res = '0;

        directed_rows = '{
            dir_row(OP_POP,    '0,            1'b1, ST_EMPTY,     '0,       0, 0),
            dir_row(OP_PEEK,   '0,            1'b1, ST_EMPTY,     '0,       0, 0),
            dir_row(OP_SEARCH, '0,            1'b1, ST_NOT_FOUND, '0,       0, 0),
            dir_row(OP_PUSH,   WORD_MIN,      1'b1, ST_OK,        WORD_MIN, 0, 1),
            dir_row(OP_PUSH,   WORD_MAX,      1'b1, ST_OK,        WORD_MAX, 1, 2),
            dir_row(OP_PUSH,   '0,            1'b1, ST_OK,        '0,       2, 3),
            dir_row(OP_PUSH,   '1,            1'b1, ST_OK,        '1,       3, 4),
            dir_row(OP_PUSH,   32'sh5a5a5a5a, 1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_PEEK,   32'sh0f0f0f0f, 1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, WORD_MIN,      1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, WORD_MAX,      1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, '1,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, 32'sh5a5a5a5a, 1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, 32'sd12345,    1'b1, ST_NOT_FOUND, '0,       0, 5),
            // duplicate value: search must report the upper copy
            dir_row(OP_PUSH,   '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_SEARCH, '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '1,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_PEEK,   '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b0, ST_OK,        '0,       0, 0),
            dir_row(OP_POP,    '0,            1'b1, ST_EMPTY,     '0,       0, 0),
            dir_row(OP_SEARCH, WORD_MIN,      1'b1, ST_NOT_FOUND, '0,       0, 0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats
        for (i = 0; i < NUM_DIRECTED; i++)
            offer(directed_rows[i].op, directed_rows[i].arg, directed_rows[i].typed,
                  directed_rows[i].res);

        // random phases: fill past full, drain past empty, then a free mix, repeated up to the target
        random_items = 0;
        ph = PHASE_FILL;
        while (random_items < RANDOM_TARGET)
        begin
            refusals = 0;
            phase_items = 0;
            while (1)
            begin
                if (random_items >= RANDOM_TARGET)
                    break;
                if (ph == PHASE_FILL && model_fill == STACK_DEPTH && refusals >= 4)
                    break;
                if (ph == PHASE_DRAIN && model_fill == 0 && refusals >= 4)
                    break;
                if (ph == PHASE_MIXED && phase_items >= 60)
                    break;
                op = choose_op(ph);
                if (op == OP_PUSH && model_fill == STACK_DEPTH)
                    refusals++;
                if ((op == OP_POP || op == OP_PEEK) && model_fill == 0)
                    refusals++;
                case (op)
                    OP_PUSH:   arg = pick_value();
                    OP_SEARCH: arg = pick_key();
                    default:   arg = $urandom;
                endcase
                steady_run = (random_items >= STEADY_FIRST && random_items < STEADY_LAST);
                offer(op, arg, 1'b0, no_res);
                random_items++;
                phase_items++;
            end
            case (ph)
                PHASE_FILL:  ph = PHASE_DRAIN;
                PHASE_DRAIN: ph = PHASE_MIXED;
                default:     ph = PHASE_FILL;
            endcase
        end
        steady_run = 1'b0;
        in_valid <= 1'b0;

        // wait for the last results, then a quiet spell
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver: random stalls, a steady stretch and one long hold-off
    initial
    begin
        int rx_cycles;
        out_ready = 1'b0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
                out_ready <= 1'b0;
            else if (steady_run)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 16);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        stack_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, status %0d word 0x%0h",
                         $time, status, word);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                report_field("status", exp_res.st, status);
                report_field("word", exp_res.value, word);
                report_field("position", exp_res.pos, position);
                report_field("fill_count", exp_res.fill, fill_count);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

### files.f
rtl/core/bsws_pkg.sv
rtl/core/bsws_ram.sv
rtl/core/bounded_stack_with_search.sv
tb/tb_top.sv
